// ===== rtl/cmbf_pkg.sv =====
// Package with shared types and constants of the capacitive-sense median baseline filter.
package cmbf_pkg;

    localparam int NUM_CHANNELS_DEF    = 8;
    localparam int RAW_WINDOW_DEF      = 5;
    localparam int MEDIAN_WINDOW_DEF   = 5;
    localparam int BASELINE_WINDOW_DEF = 5;

    localparam int CHANNEL_W   = 3;
    localparam int COUNT_W     = 16;
    localparam int PRESS_SHIFT = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_NOISE_HALF_DELTA = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECAL_LIMIT      = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLEW_DOWN        = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLEW_UP          = 8'd3;

    typedef struct packed {
        logic [14:0] noise_half_delta;
        logic [15:0] recal_limit;
        logic [15:0] slew_down;
        logic [15:0] slew_up;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   count;
        logic [CHANNEL_W-1:0] channel;
    } item_t;

endpackage

// ===== rtl/cmbf_fifo.sv =====
// Short queue that carries accepted samples from the front part to the back part.
module cmbf_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cmbf_pkg::item_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output cmbf_pkg::item_t pop_data
);
    import cmbf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/cmbf_front.sv =====
// Front part: takes sample transfers, drops unknown channels and holds the configuration.
module cmbf_front #(
    parameter int NUM_CHANNELS = cmbf_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cmbf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cmbf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                q_full,
    output logic                                q_push,
    output cmbf_pkg::item_t                     q_data,
    output cmbf_pkg::cfg_t                      cfg
);
    import cmbf_pkg::*;

    cfg_t cfg_reg;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign q_data.channel = s_tdata[CHANNEL_W-1:0];
    assign q_data.count   = s_tdata[CHANNEL_W +: COUNT_W];
    assign q_push = s_tvalid && s_tready && (int'(q_data.channel) < NUM_CHANNELS);
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.noise_half_delta <= 15'd16;
            cfg_reg.recal_limit      <= 16'd4;
            cfg_reg.slew_down        <= 16'd8;
            cfg_reg.slew_up          <= 16'd8;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_NOISE_HALF_DELTA: cfg_reg.noise_half_delta <= cfg_wdata[14:0];
                CFG_RECAL_LIMIT:      cfg_reg.recal_limit      <= cfg_wdata;
                CFG_SLEW_DOWN:        cfg_reg.slew_down        <= cfg_wdata;
                CFG_SLEW_UP:          cfg_reg.slew_up          <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/cmbf_back.sv =====
// Back part: per-channel window memories, shared sorter, press decision and baseline update.
module cmbf_back #(
    parameter int NUM_CHANNELS    = cmbf_pkg::NUM_CHANNELS_DEF,
    parameter int RAW_WINDOW      = cmbf_pkg::RAW_WINDOW_DEF,
    parameter int MEDIAN_WINDOW   = cmbf_pkg::MEDIAN_WINDOW_DEF,
    parameter int BASELINE_WINDOW = cmbf_pkg::BASELINE_WINDOW_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  cmbf_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  cmbf_pkg::item_t q_data,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [0:0]      m_tuser,
    output logic [39:0]     m_tdata
);
    import cmbf_pkg::*;

    localparam int MAXW_A = (RAW_WINDOW > MEDIAN_WINDOW) ? RAW_WINDOW : MEDIAN_WINDOW;
    localparam int MAXW   = (MAXW_A > BASELINE_WINDOW) ? MAXW_A : BASELINE_WINDOW;
    localparam int FILL_W = $clog2(MAXW + 1);
    localparam int WI_W   = (MAXW > 1) ? $clog2(MAXW) : 1;
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RD     = NUM_CHANNELS * RAW_WINDOW;
    localparam int MD     = NUM_CHANNELS * MEDIAN_WINDOW;
    localparam int BD     = NUM_CHANNELS * BASELINE_WINDOW;
    localparam int RA_W   = (RD > 1) ? $clog2(RD) : 1;
    localparam int MA_W   = (MD > 1) ? $clog2(MD) : 1;
    localparam int BA_W   = (BD > 1) ? $clog2(BD) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RAW_WR, S_LOAD, S_SORT, S_MED_WR, S_EMIT, S_BUPD
    } state_t;

    typedef enum logic [1:0] {
        ST_RAW, ST_MED, ST_BASE
    } stage_t;

    state_t state_reg;
    stage_t stage_reg;

    logic [COUNT_W-1:0] raw_mem  [RD];
    logic [COUNT_W-1:0] med_mem  [MD];
    logic [COUNT_W-1:0] base_mem [BD];
    logic [COUNT_W-1:0] raw_rd_reg, med_rd_reg, base_rd_reg;

    logic [FILL_W-1:0]  raw_fill_reg  [NUM_CHANNELS];
    logic [FILL_W-1:0]  med_fill_reg  [NUM_CHANNELS];
    logic [FILL_W-1:0]  base_fill_reg [NUM_CHANNELS];
    logic [15:0]        base_val_reg  [NUM_CHANNELS];
    logic [15:0]        mism_reg      [NUM_CHANNELS];
    logic [15:0]        last_reg      [NUM_CHANNELS];

    logic [CHANNEL_W-1:0] ch_reg;
    logic [COUNT_W-1:0]   val_reg;
    logic [FILL_W-1:0]    n_reg, k_reg, pass_reg;
    logic [COUNT_W-1:0]   work_reg  [MAXW];
    logic [COUNT_W-1:0]   work_next [MAXW];

    logic                 out_valid_reg;
    logic                 pressed_reg;
    logic [CHANNEL_W-1:0] out_ch_reg;
    logic [15:0]          out_filt_reg, out_base_reg;

    logic [CH_W-1:0]   ci;
    logic [FILL_W-1:0] ld_idx;
    logic [RA_W-1:0]   raw_addr;
    logic [MA_W-1:0]   med_addr;
    logic [BA_W-1:0]   base_addr;
    logic [COUNT_W-1:0] rd_sel;

    logic [15:0]       base_cur, m1, m2, nb, thr, dlt;
    logic [FILL_W-1:0] f_old, f_inc, f_dir;
    logic              dir_chg, mism, b_full, out_free, pressed_c, emit_fire;
    logic [15:0]       nb_new;

    assign ci = ch_reg[CH_W-1:0];
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign ld_idx = (k_reg == n_reg) ? '0 : k_reg;

    assign raw_addr  = RA_W'(int'(ci) * RAW_WINDOW +
                       int'((state_reg == S_LOAD) ? ld_idx : raw_fill_reg[ci]));
    assign med_addr  = MA_W'(int'(ci) * MEDIAN_WINDOW +
                       int'((state_reg == S_LOAD) ? ld_idx : med_fill_reg[ci]));
    assign base_addr = BA_W'(int'(ci) * BASELINE_WINDOW +
                       int'((state_reg == S_LOAD) ? ld_idx : base_fill_reg[ci]));

    always_comb begin
        case (stage_reg)
            ST_RAW:  rd_sel = raw_rd_reg;
            ST_MED:  rd_sel = med_rd_reg;
            default: rd_sel = base_rd_reg;
        endcase
    end

    always_comb begin
        for (int i = 0; i < MAXW; i++) begin
            work_next[i] = work_reg[i];
        end
        for (int i = 0; i + 1 < MAXW; i++) begin
            if ((i % 2) == int'(pass_reg[0]) && (i + 1) < int'(n_reg) &&
                work_reg[i+1] < work_reg[i]) begin
                work_next[i]   = work_reg[i+1];
                work_next[i+1] = work_reg[i];
            end
        end
    end

    assign m1 = work_reg[WI_W'(RAW_WINDOW / 2)];
    assign m2 = work_reg[WI_W'(MEDIAN_WINDOW / 2)];
    assign nb = work_reg[WI_W'(BASELINE_WINDOW / 2)];
    assign base_cur = base_val_reg[ci];
    assign thr = base_cur - (base_cur >> PRESS_SHIFT);
    assign pressed_c = (m2 < thr);
    assign out_free = !out_valid_reg || m_tready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;
    assign dlt = {cfg.noise_half_delta, 1'b0};

    always_comb begin
        f_old   = base_fill_reg[ci];
        f_inc   = f_old + 1'b1;
        dir_chg = (f_old != '0) &&
                  ((m2 > base_cur && last_reg[ci] < base_cur) ||
                   (m2 < base_cur && last_reg[ci] > base_cur));
        f_dir   = dir_chg ? '0 : f_inc;
        mism    = (f_dir != '0) && (base_cur > dlt) &&
                  ({1'b0, m2} + {1'b0, dlt} < {1'b0, base_cur}) &&
                  (mism_reg[ci] < cfg.recal_limit);
        b_full  = !mism && (f_dir == FILL_W'(BASELINE_WINDOW));
    end

    always_comb begin
        nb_new = base_cur;
        if (nb < base_cur) begin
            if (cfg.slew_down != '0 && ({1'b0, nb} + {1'b0, cfg.slew_down} < {1'b0, base_cur})
                && mism_reg[ci] < cfg.recal_limit) begin
                nb_new = base_cur - cfg.slew_down;
            end else begin
                nb_new = nb;
            end
        end else if (nb > base_cur) begin
            if (cfg.slew_up != '0 && ({1'b0, nb} > {1'b0, base_cur} + {1'b0, cfg.slew_up})) begin
                nb_new = base_cur + cfg.slew_up;
            end else begin
                nb_new = nb;
            end
        end
    end

    always_ff @(posedge aclk) begin
        raw_rd_reg  <= raw_mem[raw_addr];
        med_rd_reg  <= med_mem[med_addr];
        base_rd_reg <= base_mem[base_addr];
        if (state_reg == S_RAW_WR) begin
            raw_mem[raw_addr] <= val_reg;
        end
        if (state_reg == S_MED_WR) begin
            med_mem[med_addr] <= m1;
        end
        if (emit_fire) begin
            base_mem[base_addr] <= m2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            stage_reg     <= ST_RAW;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                raw_fill_reg[c]  <= '0;
                med_fill_reg[c]  <= '0;
                base_fill_reg[c] <= '0;
                base_val_reg[c]  <= '0;
                mism_reg[c]      <= '0;
            end
        end else begin
            if (emit_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        ch_reg    <= q_data.channel;
                        val_reg   <= q_data.count;
                        state_reg <= S_RAW_WR;
                    end
                end
                S_RAW_WR: begin
                    if (raw_fill_reg[ci] == FILL_W'(RAW_WINDOW - 1)) begin
                        raw_fill_reg[ci] <= '0;
                        stage_reg <= ST_RAW;
                        n_reg     <= FILL_W'(RAW_WINDOW);
                        k_reg     <= '0;
                        state_reg <= S_LOAD;
                    end else begin
                        raw_fill_reg[ci] <= raw_fill_reg[ci] + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_LOAD: begin
                    if (k_reg != '0) begin
                        work_reg[WI_W'(k_reg - 1'b1)] <= rd_sel;
                    end
                    if (k_reg == n_reg) begin
                        pass_reg  <= '0;
                        state_reg <= S_SORT;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_SORT: begin
                    for (int i = 0; i < MAXW; i++) begin
                        work_reg[i] <= work_next[i];
                    end
                    pass_reg <= pass_reg + 1'b1;
                    if (pass_reg == n_reg - 1'b1) begin
                        case (stage_reg)
                            ST_RAW:  state_reg <= S_MED_WR;
                            ST_MED:  state_reg <= S_EMIT;
                            default: state_reg <= S_BUPD;
                        endcase
                    end
                end
                S_MED_WR: begin
                    if (med_fill_reg[ci] == FILL_W'(MEDIAN_WINDOW - 1)) begin
                        med_fill_reg[ci] <= '0;
                        stage_reg <= ST_MED;
                        n_reg     <= FILL_W'(MEDIAN_WINDOW);
                        k_reg     <= '0;
                        state_reg <= S_LOAD;
                    end else begin
                        med_fill_reg[ci] <= med_fill_reg[ci] + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_ch_reg    <= ch_reg;
                        pressed_reg   <= pressed_c;
                        out_filt_reg  <= m2;
                        out_base_reg  <= base_cur;
                        last_reg[ci]  <= m2;
                        if (mism) begin
                            mism_reg[ci] <= mism_reg[ci] + 1'b1;
                        end
                        if (b_full) begin
                            stage_reg <= ST_BASE;
                            n_reg     <= FILL_W'(BASELINE_WINDOW);
                            k_reg     <= '0;
                            state_reg <= S_LOAD;
                        end else begin
                            base_fill_reg[ci] <= mism ? '0 : f_dir;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_BUPD: begin
                    base_val_reg[ci]  <= nb_new;
                    base_fill_reg[ci] <= '0;
                    mism_reg[ci]      <= '0;
                    state_reg         <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = pressed_reg;
    assign m_tdata  = {5'd0, out_base_reg, out_filt_reg, out_ch_reg};

endmodule

// ===== rtl/capsense_median_baseline_filter.sv =====
// Top level of the capacitive-sense median filter with baseline tracking.
//
// Samples arrive as transfers on the s_ channel: s_tdata holds the channel number and the
// raw count. Samples of channels at or above NUM_CHANNELS are taken and dropped. Each
// sample enters a four-entry queue; the back part takes one sample at a time from it.
// A sample that does not complete a raw window is only written to its raw window. A
// sample that completes a raw window then goes through the sequential load from the window
// memory and the odd-even sort passes of the shared sorter, and its median is written to
// the median window; completing a median window loads and sorts again and emits one result,
// and a full baseline window loads and sorts once more for the baseline update.
// Results leave through an output register on the m_ channel; while the receiver
// stalls, the back part waits at the result step and the queue keeps taking samples
// until it is full. Configuration writes on the cfg_ channel are always taken.
// Reset clears all fill counts, baselines, mismatch counts and restores the registers.
module capsense_median_baseline_filter #(
    parameter int NUM_CHANNELS    = cmbf_pkg::NUM_CHANNELS_DEF,
    parameter int RAW_WINDOW      = cmbf_pkg::RAW_WINDOW_DEF,
    parameter int MEDIAN_WINDOW   = cmbf_pkg::MEDIAN_WINDOW_DEF,
    parameter int BASELINE_WINDOW = cmbf_pkg::BASELINE_WINDOW_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // channel[2:0], count[18:3]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [0:0]                      m_tuser,   // pressed[0]
    output logic [39:0]                     m_tdata,   // out_channel[2:0],
                                                       // filtered_value[18:3], baseline[34:19]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cmbf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cmbf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cmbf_pkg::*;

    logic  q_full, q_push, q_pop, q_valid;
    item_t q_in, q_out;
    cfg_t  cfg;

    cmbf_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .q_full(q_full), .q_push(q_push), .q_data(q_in), .cfg(cfg)
    );

    cmbf_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_valid), .pop_data(q_out)
    );

    cmbf_back #(
        .NUM_CHANNELS(NUM_CHANNELS), .RAW_WINDOW(RAW_WINDOW),
        .MEDIAN_WINDOW(MEDIAN_WINDOW), .BASELINE_WINDOW(BASELINE_WINDOW)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
    );

endmodule

// ===== rtl/cmbf_checker.sv =====
// Port-level checker of the filter and its bind to the top level.
module cmbf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [0:0]  m_tuser,
    input logic [39:0] m_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transfer withdrawn while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_press_below: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[18:3] < m_tdata[34:19])
        else $error("press reported above baseline");

endmodule

bind capsense_median_baseline_filter cmbf_checker u_cmbf_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for the capacitive-sense median baseline filter.
module testbench;
    import cmbf_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNKNOWN_LOW  = 8'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNKNOWN_HIGH = 8'hFF;

    typedef struct packed {
        logic [2:0]  channel;
        logic        pressed;
        logic [15:0] filtered;
        logic [15:0] baseline;
    } press_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [0:0]  m_tuser;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    capsense_median_baseline_filter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    press_result_t pending_results[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;

    int noise_half_delta = 16;
    int recal_limit = 4;
    int slew_down = 8;
    int slew_up = 8;

    logic [4:0][15:0] raw_win [8];
    logic [4:0][15:0] med_win [8];
    logic [4:0][15:0] base_win [8];
    int raw_fill [8];
    int med_fill [8];
    int base_fill [8];
    logic [15:0] base_val [8];
    int mismatch_cnt [8];
    int level [8];

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8000000;
        $display("testbench failed");
        $finish;
    end

    function automatic logic [15:0] median5(input logic [4:0][15:0] w);
        logic [15:0] v;
        int k;
        for (int i = 1; i < 5; i++) begin
            v = w[i];
            k = i;
            while (k > 0 && v < w[k-1]) begin
                w[k] = w[k-1];
                k--;
            end
            w[k] = v;
        end
        return w[2];
    endfunction

    task automatic track_baseline(input int c, input logic [15:0] m);
        int base, f, a, b, d, nb;
        base = int'(base_val[c]);
        f = base_fill[c];
        if (f >= 5) f = 0;
        base_win[c][f] = m;
        f++;
        if (f > 1) begin
            a = int'(base_win[c][f-1]);
            b = int'(base_win[c][f-2]);
            if ((a > base && b < base) || (a < base && b > base)) f = 0;
        end
        if (f > 0) begin
            a = int'(base_win[c][f-1]);
            d = 2 * noise_half_delta;
            if (base > d && a < base - d && mismatch_cnt[c] < recal_limit) begin
                mismatch_cnt[c]++;
                f = 0;
            end
        end
        if (f >= 5) begin
            nb = int'(median5(base_win[c]));
            if (nb < base) begin
                if (slew_down > 0 && nb < base - slew_down && mismatch_cnt[c] < recal_limit)
                    base -= slew_down;
                else
                    base = nb;
            end else if (nb > base) begin
                if (slew_up > 0 && nb > base + slew_up)
                    base += slew_up;
                else
                    base = nb;
            end
            base_val[c] = base[15:0];
            f = 0;
            mismatch_cnt[c] = 0;
        end
        base_fill[c] = f;
    endtask

    task automatic predict_sample(input int c, input logic [15:0] cnt);
        press_result_t r;
        logic [15:0] med;
        int thr;
        if (raw_fill[c] >= 5) raw_fill[c] = 0;
        raw_win[c][raw_fill[c]] = cnt;
        raw_fill[c]++;
        if (raw_fill[c] < 5) return;
        raw_fill[c] = 0;
        if (med_fill[c] >= 5) med_fill[c] = 0;
        med_win[c][med_fill[c]] = median5(raw_win[c]);
        med_fill[c]++;
        if (med_fill[c] < 5) return;
        med_fill[c] = 0;
        med = median5(med_win[c]);
        thr = int'(base_val[c]) - int'(base_val[c] >> PRESS_SHIFT);
        r.channel = c[2:0];
        r.pressed = (int'(med) < thr);
        r.filtered = med;
        r.baseline = base_val[c];
        pending_results.push_back(r);
        track_baseline(c, med);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        press_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, channel", m_tdata[2:0], -1);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] != want.channel)
                    report_mismatch("channel", m_tdata[2:0], want.channel);
                if (m_tuser[0] != want.pressed)
                    report_mismatch("pressed", m_tuser[0], want.pressed);
                if (m_tdata[18:3] != want.filtered)
                    report_mismatch("filtered value", m_tdata[18:3], want.filtered);
                if (m_tdata[34:19] != want.baseline)
                    report_mismatch("baseline", m_tdata[34:19], want.baseline);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_sample(input int c, input logic [15:0] cnt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, cnt, c[2:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_sample(c, cnt);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NOISE_HALF_DELTA: noise_half_delta = int'(value[14:0]);
            CFG_RECAL_LIMIT:      recal_limit = int'(value);
            CFG_SLEW_DOWN:        slew_down = int'(value);
            CFG_SLEW_UP:          slew_up = int'(value);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    task automatic configure(input int nhd, input int rl, input int sd, input int su);
        write_reg(CFG_NOISE_HALF_DELTA, nhd[15:0]);
        write_reg(CFG_RECAL_LIMIT, rl[15:0]);
        write_reg(CFG_SLEW_DOWN, sd[15:0]);
        write_reg(CFG_SLEW_UP, su[15:0]);
    endtask

    task automatic random_count(input int c, output logic [15:0] cnt);
        int r, v;
        r = $urandom_range(0, 99);
        if (r < 3) level[c] = $urandom_range(0, 65535);
        if (r < 8) begin
            v = $urandom_range(0, 65535);
        end else if (r < 20) begin
            v = level[c] - $urandom_range(0, level[c] / 3 + 200);
        end else begin
            v = level[c] + $urandom_range(0, 40) - 20;
        end
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        cnt = v[15:0];
    endtask

    task automatic test_random_phase(input int n_items);
        int c;
        logic [15:0] cnt;
        for (int i = 0; i < n_items; i++) begin
            c = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 1) : $urandom_range(0, 7);
            random_count(c, cnt);
            send_sample(c, cnt);
        end
        drain_results();
    endtask

    task automatic test_directed();
        logic [15:0] pattern [5] = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h8001};
        write_reg(CFG_UNKNOWN_LOW, 16'hFFFF);
        write_reg(CFG_UNKNOWN_HIGH, 16'h1234);
        for (int i = 0; i < 25; i++) send_sample(7, pattern[i % 5]);
        send_sample(0, 16'hFFFF);
        send_sample(3, 16'h0000);
        drain_results();
    endtask

    task automatic test_input_stall();
        logic [15:0] cnt;
        hold_off_cycles = 1500;
        for (int i = 0; i < 200; i++) begin
            random_count(i % 2, cnt);
            send_sample(i % 2, cnt);
        end
        drain_results();
    endtask

    initial begin
        for (int c = 0; c < 8; c++) begin
            raw_fill[c] = 0;
            med_fill[c] = 0;
            base_fill[c] = 0;
            base_val[c] = '0;
            mismatch_cnt[c] = 0;
            level[c] = $urandom_range(2000, 60000);
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 15;
        recv_idle_pct = 51;
        test_directed();
        configure(0, 0, 0, 0);
        test_random_phase(420);
        send_idle_pct = 51;
        recv_idle_pct = 15;
        configure(32767, 65535, 65535, 65535);
        test_random_phase(420);
        test_input_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure($urandom_range(0, 300), $urandom_range(1, 3),
                  $urandom_range(1, 3000), $urandom_range(1, 3000));
        test_random_phase(420);
        configure(16, 4, 8, 8);
        test_random_phase(420);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
